[sv/servo_reply_packet_parser_assert.svh]
// ----------------------------------------------------------------------------
// Servo reply packet parser assertion macros
// Shared forms for the concurrent checks of the reply parser.
// ----------------------------------------------------------------------------
`ifndef SERVO_REPLY_PACKET_PARSER_ASSERT_SVH
`define SERVO_REPLY_PACKET_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRPP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/srpp_pkg.sv]
// ----------------------------------------------------------------------------
// Servo reply packet parser package
// Item types, codes and helpers shared by the parser modules.
// ----------------------------------------------------------------------------
package srpp_pkg;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
      logic [7:0] expected_id;
      logic [7:0] param_count;
      logic       check_id;
      logic       check_length;
      logic       check_sum;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [2:0] status;
      logic [7:0] servo_error;
      logic [7:0] reply_id;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_ARM  = 2'd0,
      OP_BYTE = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_HUNT  = 3'd1,
      PH_ID    = 3'd2,
      PH_LEN   = 3'd3,
      PH_ERR   = 3'd4,
      PH_PARAM = 3'd5,
      PH_SUM   = 3'd6
   } phase_type;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NO_HEADER = 3'd1;
   localparam logic [2:0] STATUS_ID_BAD    = 3'd2;
   localparam logic [2:0] STATUS_LEN_BAD   = 3'd3;
   localparam logic [2:0] STATUS_SUM_BAD   = 3'd4;
   localparam logic [2:0] STATUS_TIMEOUT   = 3'd5;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam int FLAG_ID  = 0;
   localparam int FLAG_LEN = 1;
   localparam int FLAG_SUM = 2;

   localparam logic [7:0]  HEADER_BYTE   = 8'hFF;
   localparam logic [8:0]  LEN_OVERHEAD  = 9'd2;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam int          STRAY_W       = 4;

   function automatic rsp_type make_status(input logic [2:0] code,
                                           input logic [7:0] err,
                                           input logic [7:0] id);
      rsp_type r;
      r.kind        = KIND_STATUS;
      r.data_byte   = 8'd0;
      r.status      = code;
      r.servo_error = err;
      r.reply_id    = id;
      return r;
   endfunction

   function automatic rsp_type make_data(input logic [7:0] b, input logic [7:0] id);
      rsp_type r;
      r.kind        = KIND_DATA;
      r.data_byte   = b;
      r.status      = STATUS_OK;
      r.servo_error = 8'd0;
      r.reply_id    = id;
      return r;
   endfunction

endpackage

[sv/servo_reply_packet_parser.sv]
// ----------------------------------------------------------------------------
// Servo reply packet parser
// Parses a servo status reply one byte per item and reports its parameters
// and a final status.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the input side stalls. An
// accepted item goes into the input register and its result into the result
// register, with the reply state register in between updated once per item.
// An arm item sets up a reply, byte items move it along and tick
// items count idle time; each item gives at most one result, either a
// parameter byte or a final status that returns the block to idle. The input
// side stalls only while a finished result is held by a stalled consumer and
// another item already waits in the input register. The timeout register may
// be written at any time through the csr port, which never stalls.
module servo_reply_packet_parser
   import srpp_pkg::*;
#(
   parameter int HUNT_LIMIT = 10
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic    item_valid;
   req_type item;
   logic    out_ready;
   logic    advance;
   logic    res_valid;
   rsp_type res_item;

   assign advance   = item_valid && out_ready;
   assign csr_ready = 1'b1;

   srpp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   srpp_core #(
      .HUNT_LIMIT (HUNT_LIMIT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   srpp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_item  (res_item),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

[sv/srpp_in_stage.sv]
// ----------------------------------------------------------------------------
// Servo reply parser input stage
// Holds one accepted item until the parser core takes it.
// ----------------------------------------------------------------------------
module srpp_in_stage
   import srpp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   input  logic    advance,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;
   logic    take;

   // The stage refills in the same cycle that it hands its item on.
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      item_in  = take ? req_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[sv/srpp_core.sv]
// ----------------------------------------------------------------------------
// Servo reply parser core
// Reply state machine, checksum and timeout; one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module srpp_core
   import srpp_pkg::*;
#(
   parameter int HUNT_LIMIT = 10
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  req_type     item,
   input  logic        csr_write,
   input  logic [15:0] csr_data,
   output logic        res_valid,
   output rsp_type     res_item
);

   localparam logic [STRAY_W-1:0] HuntMax = STRAY_W'(HUNT_LIMIT);

   phase_type          phase_ff, phase_in;
   logic [STRAY_W-1:0] stray_ff, stray_in;
   logic               prev_ff_ff, prev_ff_in;
   logic [7:0]         want_id_ff, want_id_in;
   logic [7:0]         want_count_ff, want_count_in;
   logic [2:0]         flags_ff, flags_in;
   logic [7:0]         left_ff, left_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         got_id_ff, got_id_in;
   logic [7:0]         got_error_ff, got_error_in;
   logic [15:0]        idle_ff, idle_in;
   logic [15:0]        timeout_ff;
   logic [7:0]         b;

   assign b = item.rx_byte;

   always_comb begin
      phase_in      = phase_ff;
      stray_in      = stray_ff;
      prev_ff_in    = prev_ff_ff;
      want_id_in    = want_id_ff;
      want_count_in = want_count_ff;
      flags_in      = flags_ff;
      left_in       = left_ff;
      sum_in        = sum_ff;
      got_id_in     = got_id_ff;
      got_error_in  = got_error_ff;
      idle_in       = idle_ff;
      res_valid     = 1'b0;
      res_item      = '0;
      if (advance) begin
         case (item.op)
            OP_ARM: begin
               want_id_in    = item.expected_id;
               want_count_in = item.param_count;
               flags_in      = {item.check_sum, item.check_length, item.check_id};
               phase_in      = PH_HUNT;
               stray_in      = '0;
               prev_ff_in    = 1'b0;
               left_in       = 8'd0;
               sum_in        = 8'd0;
               got_id_in     = 8'd0;
               got_error_in  = 8'd0;
               idle_in       = 16'd0;
            end
            OP_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (idle_ff >= timeout_ff) begin
                     res_valid = 1'b1;
                     res_item  = make_status(STATUS_TIMEOUT, got_error_ff, got_id_ff);
                     phase_in  = PH_IDLE;
                  end else begin
                     idle_in = idle_ff + 16'd1;
                  end
               end
            end
            OP_BYTE: begin
               if (phase_ff != PH_IDLE) begin
                  idle_in = 16'd0;
                  unique case (phase_ff)
                     PH_HUNT: begin
                        if (b == HEADER_BYTE && prev_ff_ff) begin
                           phase_in = PH_ID;
                        end else begin
                           prev_ff_in = (b == HEADER_BYTE);
                           if (stray_ff >= HuntMax) begin
                              res_valid = 1'b1;
                              res_item  = make_status(STATUS_NO_HEADER, got_error_ff,
                                                      got_id_ff);
                              phase_in  = PH_IDLE;
                           end else begin
                              stray_in = stray_ff + STRAY_W'(1);
                           end
                        end
                     end
                     PH_ID: begin
                        got_id_in = b;
                        sum_in    = b;
                        phase_in  = PH_LEN;
                     end
                     PH_LEN: begin
                        // The length byte waits in the parameter counter for its check.
                        sum_in   = sum_ff + b;
                        left_in  = b;
                        phase_in = PH_ERR;
                     end
                     PH_ERR: begin
                        got_error_in = b;
                        sum_in       = sum_ff + b;
                        if (flags_ff[FLAG_ID] && got_id_ff != want_id_ff) begin
                           res_valid = 1'b1;
                           res_item  = make_status(STATUS_ID_BAD, b, got_id_ff);
                           phase_in  = PH_IDLE;
                        end else if (flags_ff[FLAG_LEN] &&
                                     {1'b0, left_ff} != {1'b0, want_count_ff} + LEN_OVERHEAD)
                        begin
                           res_valid = 1'b1;
                           res_item  = make_status(STATUS_LEN_BAD, b, got_id_ff);
                           phase_in  = PH_IDLE;
                        end else begin
                           left_in  = want_count_ff;
                           phase_in = (want_count_ff == 8'd0) ? PH_SUM : PH_PARAM;
                        end
                     end
                     PH_PARAM: begin
                        sum_in    = sum_ff + b;
                        left_in   = left_ff - 8'd1;
                        if (left_ff == 8'd1) begin
                           phase_in = PH_SUM;
                        end
                        res_valid = 1'b1;
                        res_item  = make_data(b, got_id_ff);
                     end
                     PH_SUM: begin
                        res_valid = 1'b1;
                        phase_in  = PH_IDLE;
                        if (flags_ff[FLAG_SUM] && ~sum_ff != b) begin
                           res_item = make_status(STATUS_SUM_BAD, got_error_ff, got_id_ff);
                        end else begin
                           res_item = make_status(STATUS_OK, got_error_ff, got_id_ff);
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         stray_ff      <= '0;
         prev_ff_ff    <= 1'b0;
         want_id_ff    <= 8'd0;
         want_count_ff <= 8'd0;
         flags_ff      <= 3'd0;
         left_ff       <= 8'd0;
         sum_ff        <= 8'd0;
         got_id_ff     <= 8'd0;
         got_error_ff  <= 8'd0;
         idle_ff       <= 16'd0;
         timeout_ff    <= TIMEOUT_RESET;
      end else begin
         phase_ff      <= phase_in;
         stray_ff      <= stray_in;
         prev_ff_ff    <= prev_ff_in;
         want_id_ff    <= want_id_in;
         want_count_ff <= want_count_in;
         flags_ff      <= flags_in;
         left_ff       <= left_in;
         sum_ff        <= sum_in;
         got_id_ff     <= got_id_in;
         got_error_ff  <= got_error_in;
         idle_ff       <= idle_in;
         if (csr_write) begin
            timeout_ff <= csr_data;
         end
      end
   end

endmodule

[sv/srpp_out_stage.sv]
// ----------------------------------------------------------------------------
// Servo reply parser result stage
// Result register that holds an item while the consumer stalls.
// ----------------------------------------------------------------------------
module srpp_out_stage
   import srpp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    res_valid,
   input  rsp_type res_item,
   output logic    out_ready,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic    valid_ff, valid_in;
   rsp_type item_ff, item_in;

   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = out_ready ? res_valid : valid_ff;
      item_in  = (out_ready && res_valid) ? res_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

[sv/srpp_checker.sv]
// ----------------------------------------------------------------------------
// Servo reply parser checker
// Port-level checks on the parser's handshakes and result items.
// ----------------------------------------------------------------------------
`include "servo_reply_packet_parser_assert.svh"

module srpp_checker
   import srpp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_item
);

   // A stalled result item stays in place.
   `SRPP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item), "stalled result item changed")

   // The input side only backs up behind a stalled result.
   `SRPP_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled without a stalled result")

   // Parameter items carry no status and no servo error.
   `SRPP_ASSERT_SAME(a_data_clean, clock, reset, rsp_valid && rsp_item.kind == KIND_DATA, rsp_item.status == STATUS_OK && rsp_item.servo_error == 8'd0, "parameter item with status fields set")

endmodule

bind servo_reply_packet_parser srpp_checker u_srpp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

[tb/servo_reply_packet_parser_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo reply packet parser testbench
// Feeds arm, byte and tick items through the request channel and compares
// every parameter byte and final status against a cycle-free predictor of
// the reply parser, across several timeout settings and idling patterns.
// ----------------------------------------------------------------------------
module servo_reply_packet_parser_test;
   import srpp_pkg::*;

   localparam int         HUNT_LIMIT      = 10;
   localparam logic [1:0] OP_SPARE        = 2'd3;
   localparam int         QUIET_LIMIT     = 2000;
   localparam int         SETTLE_CYCLES   = 6;
   localparam int         ITEMS_PER_PHASE = 225;
   localparam int         REPORT_LIMIT    = 10;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_item  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_item;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data  = '0;

   req_type pending_items[$];
   rsp_type reply_results_due[$];
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      mismatch_count = 0;
   int      quiet_cycles   = 0;
   int      items_queued   = 0;

   // Predicted parser state.
   logic [15:0] timeout_reg = TIMEOUT_RESET;
   phase_type   ph          = PH_IDLE;
   logic [3:0]  stray_cnt   = '0;
   logic        prev_ff     = 1'b0;
   logic [7:0]  want_id     = '0;
   logic [7:0]  want_count  = '0;
   logic [2:0]  check_en    = '0;
   logic [7:0]  bytes_left  = '0;
   logic [7:0]  sum8        = '0;
   logic [7:0]  got_id      = '0;
   logic [7:0]  got_err     = '0;
   logic [15:0] idle_ticks  = '0;

   servo_reply_packet_parser #(.HUNT_LIMIT(HUNT_LIMIT)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   function automatic rsp_type end_reply(input logic [2:0] code);
      rsp_type r;
      r.kind        = KIND_STATUS;
      r.data_byte   = '0;
      r.status      = code;
      r.servo_error = got_err;
      r.reply_id    = got_id;
      ph            = PH_IDLE;
      return r;
   endfunction

   task automatic parse_item(input req_type it);
      rsp_type r;
      logic    emit;
      emit = 1'b0;
      r    = '0;
      case (it.op)
         OP_ARM: begin
            want_id    = it.expected_id;
            want_count = it.param_count;
            check_en   = {it.check_sum, it.check_length, it.check_id};
            ph         = PH_HUNT;
            stray_cnt  = '0;
            prev_ff    = 1'b0;
            bytes_left = '0;
            sum8       = '0;
            got_id     = '0;
            got_err    = '0;
            idle_ticks = '0;
         end
         OP_TICK: begin
            if (ph != PH_IDLE) begin
               if (idle_ticks >= timeout_reg) begin
                  r    = end_reply(STATUS_TIMEOUT);
                  emit = 1'b1;
               end else begin
                  idle_ticks = idle_ticks + 16'd1;
               end
            end
         end
         OP_BYTE: begin
            if (ph != PH_IDLE) begin
               idle_ticks = '0;
               case (ph)
                  PH_HUNT: begin
                     if (it.rx_byte == HEADER_BYTE && prev_ff) begin
                        ph = PH_ID;
                     end else begin
                        prev_ff = (it.rx_byte == HEADER_BYTE);
                        if (stray_cnt >= HUNT_LIMIT) begin
                           r    = end_reply(STATUS_NO_HEADER);
                           emit = 1'b1;
                        end else begin
                           stray_cnt = stray_cnt + 4'd1;
                        end
                     end
                  end
                  PH_ID: begin
                     got_id = it.rx_byte;
                     sum8   = it.rx_byte;
                     ph     = PH_LEN;
                  end
                  PH_LEN: begin
                     sum8       = sum8 + it.rx_byte;
                     bytes_left = it.rx_byte;
                     ph         = PH_ERR;
                  end
                  PH_ERR: begin
                     got_err = it.rx_byte;
                     sum8    = sum8 + it.rx_byte;
                     emit    = 1'b1;
                     // The id check takes priority over the length check.
                     if (check_en[FLAG_ID] && got_id != want_id) begin
                        r = end_reply(STATUS_ID_BAD);
                     end else if (check_en[FLAG_LEN] &&
                                  {1'b0, bytes_left} != {1'b0, want_count} + LEN_OVERHEAD) begin
                        r = end_reply(STATUS_LEN_BAD);
                     end else begin
                        emit       = 1'b0;
                        bytes_left = want_count;
                        if (want_count == 8'd0) begin
                           ph = PH_SUM;
                        end else begin
                           ph = PH_PARAM;
                        end
                     end
                  end
                  PH_PARAM: begin
                     sum8       = sum8 + it.rx_byte;
                     bytes_left = bytes_left - 8'd1;
                     if (bytes_left == 8'd0) begin
                        ph = PH_SUM;
                     end
                     r.kind        = KIND_DATA;
                     r.data_byte   = it.rx_byte;
                     r.status      = STATUS_OK;
                     r.servo_error = '0;
                     r.reply_id    = got_id;
                     emit          = 1'b1;
                  end
                  PH_SUM: begin
                     emit = 1'b1;
                     if (check_en[FLAG_SUM] && ~sum8 != it.rx_byte) begin
                        r = end_reply(STATUS_SUM_BAD);
                     end else begin
                        r = end_reply(STATUS_OK);
                     end
                  end
                  default: begin
                     ph = PH_IDLE;
                  end
               endcase
            end
         end
         default: ;
      endcase
      if (emit) begin
         reply_results_due.push_back(r);
      end
   endtask

   // Request driver: a new item is offered only when the slot is free.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_item(req_item);
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_item  <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver stall.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall    <= 1'b0;
         quiet_cycles = 0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (reply_results_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result kind %0d data %02h status %0d err %02h id %02h",
                           $realtime, rsp_item.kind, rsp_item.data_byte, rsp_item.status,
                           rsp_item.servo_error, rsp_item.reply_id);
               end
            end else begin
               want = reply_results_due.pop_front();
               if (want.kind !== rsp_item.kind || want.data_byte !== rsp_item.data_byte ||
                   want.status !== rsp_item.status ||
                   want.servo_error !== rsp_item.servo_error ||
                   want.reply_id !== rsp_item.reply_id) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: expected kind %0d data %02h status %0d err %02h id %02h",
                              $realtime, want.kind, want.data_byte, want.status,
                              want.servo_error, want.reply_id);
                     $display("%0t:      got kind %0d data %02h status %0d err %02h id %02h",
                              $realtime, rsp_item.kind, rsp_item.data_byte, rsp_item.status,
                              rsp_item.servo_error, rsp_item.reply_id);
                  end
               end
            end
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic push_item(input logic [1:0] op, input logic [7:0] b);
      req_type     r;
      logic [31:0] raw;
      raw       = $urandom;
      r         = raw[$bits(req_type)-1:0];
      r.op      = op;
      r.rx_byte = b;
      pending_items.push_back(r);
      items_queued++;
   endtask

   task automatic push_arm(input logic [7:0] id, input logic [7:0] count,
                           input logic [2:0] flags);
      req_type     r;
      logic [31:0] raw;
      raw           = $urandom;
      r             = raw[$bits(req_type)-1:0];
      r.op          = OP_ARM;
      r.expected_id = id;
      r.param_count = count;
      r.check_id    = flags[FLAG_ID];
      r.check_length = flags[FLAG_LEN];
      r.check_sum   = flags[FLAG_SUM];
      pending_items.push_back(r);
      items_queued++;
   endtask

   // Any op, any field values; these do not count toward the phase size.
   task automatic push_noise();
      logic [31:0] raw;
      raw = $urandom;
      pending_items.push_back(raw[$bits(req_type)-1:0]);
   endtask

   // Header, id, length, error, parameters and checksum, with optional ticks
   // before any byte. A non-negative cut drops the frame from that byte on.
   task automatic push_frame(input logic [7:0] id, input logic [7:0] len_byte,
                             input logic [7:0] err, input int nparam, input bit sum_good,
                             input int tick_pct, input int cut);
      logic [7:0] frame[$];
      logic [7:0] s;
      logic [7:0] b;
      int         max_ticks;
      frame.push_back(HEADER_BYTE);
      frame.push_back(HEADER_BYTE);
      frame.push_back(id);
      frame.push_back(len_byte);
      frame.push_back(err);
      s = id + len_byte + err;
      repeat (nparam) begin
         b = 8'($urandom);
         frame.push_back(b);
         s = s + b;
      end
      if (sum_good) begin
         frame.push_back(~s);
      end else begin
         frame.push_back(8'($urandom));
      end
      max_ticks = (timeout_reg < 30) ? timeout_reg + 2 : 30;
      foreach (frame[k]) begin
         if (k == cut) begin
            break;
         end
         if ($urandom_range(99) < tick_pct) begin
            repeat ($urandom_range(1, max_ticks)) push_item(OP_TICK, 8'($urandom));
         end
         push_item(OP_BYTE, frame[k]);
      end
   endtask

   task automatic push_random_reply();
      logic [7:0] id;
      logic [7:0] count;
      logic [7:0] len_byte;
      logic [2:0] flags;
      int         sel;
      int         cut;
      id  = 8'($urandom);
      sel = $urandom_range(99);
      if (sel < 3) begin
         count = 8'($urandom_range(253, 255));
      end else begin
         count = 8'($urandom_range(0, 6));
      end
      flags = 3'($urandom);
      push_arm(id, count, flags);
      // Leading garbage; the long runs straddle the hunt limit.
      sel = $urandom_range(99);
      if (sel < 8) begin
         repeat ($urandom_range(HUNT_LIMIT, HUNT_LIMIT + 3))
            push_item(OP_BYTE, 8'($urandom_range(0, 254)));
      end else if (sel < 40) begin
         repeat ($urandom_range(1, 3)) push_item(OP_BYTE, 8'($urandom));
      end
      if ($urandom_range(99) < 20) begin
         id = 8'($urandom);
      end
      if ($urandom_range(99) < 20) begin
         len_byte = 8'($urandom);
      end else begin
         len_byte = count + 8'd2;
      end
      cut = ($urandom_range(99) < 12) ? $urandom_range(0, count + 5) : -1;
      push_frame(id, len_byte, 8'($urandom), count, $urandom_range(99) < 85, 15, cut);
      if (cut >= 0 && timeout_reg <= 40 && $urandom_range(1) == 1) begin
         repeat (timeout_reg + 1) push_item(OP_TICK, 8'($urandom));
      end
   endtask

   task automatic write_timeout(input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid   <= 1'b0;
      timeout_reg = value;
      @(negedge clock);
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || req_valid || reply_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input logic [15:0] limit);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      write_timeout(limit);
      items_queued = 0;
      while (items_queued < ITEMS_PER_PHASE) begin
         if ($urandom_range(99) < 10) begin
            push_noise();
         end else begin
            push_random_reply();
         end
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_timeout(16'd1);

      // Items while idle are dropped, including the unused op.
      push_item(OP_BYTE, 8'hFF);
      push_item(OP_TICK, 8'h00);
      push_item(OP_SPARE, 8'h00);
      // Clean reply with one parameter and every check on.
      push_arm(8'hFF, 8'd1, 3'b111);
      push_frame(8'hFF, 8'd3, 8'hFF, 1, 1'b1, 0, -1);
      // A count of 254 never matches the length byte, even a wrapped one.
      push_arm(8'h00, 8'd254, 3'b011);
      push_frame(8'h00, 8'd0, 8'h00, 0, 1'b1, 0, 5);
      // No length check, no parameters, bad checksum.
      push_arm(8'h00, 8'd0, 3'b100);
      push_frame(8'h00, 8'd9, 8'h80, 0, 1'b0, 0, -1);
      // One stray past the hunt limit ends the reply.
      push_arm(8'h5A, 8'd0, 3'b000);
      push_item(OP_BYTE, 8'h00);
      push_item(OP_BYTE, 8'hFF);
      push_item(OP_BYTE, 8'h00);
      for (int k = 1; k <= 8; k++) begin
         push_item(OP_BYTE, 8'(k));
      end
      // A received byte restarts the idle count before the timeout.
      push_arm(8'h33, 8'd2, 3'b111);
      push_item(OP_TICK, 8'h00);
      push_item(OP_BYTE, 8'h00);
      push_item(OP_TICK, 8'h00);
      push_item(OP_TICK, 8'h00);
      drain();

      run_phase(0, 0, 16'hFFFF);
      run_phase(87, 0, 16'd3);
      run_phase(0, 87, 16'($urandom_range(1, 40)));
      run_phase(30, 30, 16'd12);

      if (mismatch_count == 0 && reply_results_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/srpp_pkg.sv
sv/srpp_in_stage.sv
sv/srpp_core.sv
sv/srpp_out_stage.sv
sv/servo_reply_packet_parser.sv
sv/srpp_checker.sv
tb/servo_reply_packet_parser_test.sv
